@@ src/macc_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// macc_pkg
// Shared types, codes and display helpers of the menu alarm clock controller.
// ---------------------------------------------------------------------------
package macc_pkg;

    localparam logic [4:0] TIMER_DAY_SPAN = 5'd30;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_NEXT    = 2'd1,
        CMD_CONFIRM = 2'd2,
        CMD_SAMPLE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        MODE_SHOW_CLOCK = 4'd0,
        MODE_SHOW_LIGHT = 4'd1,
        MODE_SET_CLOCK  = 4'd2,
        MODE_SET_TIMER  = 4'd3,
        MODE_SET_LIGHT  = 4'd4,
        MODE_CLR_TIMER  = 4'd5,
        MODE_CLR_LIGHT  = 4'd6,
        MODE_MENU       = 4'd7,
        MODE_ALARM      = 4'd8
    } mode_t;

    localparam logic [1:0] GRP_GET   = 2'd0;
    localparam logic [1:0] GRP_SET   = 2'd1;
    localparam logic [1:0] GRP_CLEAR = 2'd2;

    localparam logic [1:0] TFIELD_DAY    = 2'd0;
    localparam logic [1:0] TFIELD_HOUR   = 2'd1;
    localparam logic [1:0] TFIELD_MINUTE = 2'd2;

    // letter patterns
    localparam logic [7:0] SEG_G  = 8'h3d;
    localparam logic [7:0] SEG_E  = 8'h79;
    localparam logic [7:0] SEG_T  = 8'h31;
    localparam logic [7:0] SEG_S  = 8'h6d;
    localparam logic [7:0] SEG_C  = 8'h39;
    localparam logic [7:0] SEG_L  = 8'h38;
    localparam logic [7:0] SEG_D  = 8'h5e;
    localparam logic [7:0] SEG_Y  = 8'h6e;
    localparam logic [7:0] SEG_A  = 8'h77;
    localparam logic [7:0] SEG_N  = 8'h37;
    localparam logic [7:0] SEG_DP = 8'h80;

    // index 0 is the leftmost digit
    typedef logic [3:0][7:0] seg_quad_t;

    // post-update state that the display decodes
    typedef struct packed {
        mode_t       mode;
        logic [2:0]  menu_pos;
        logic [1:0]  menu_group;
        logic [4:0]  clk_hour;
        logic [5:0]  clk_minute;
        logic [4:0]  alm_day;
        logic [4:0]  alm_hour;
        logic [5:0]  alm_minute;
        logic [3:0]  light_low;
        logic [3:0]  light_high;
        logic [3:0]  light_level;
        logic [1:0]  timer_field_sel;
        logic        timer_on;
        logic        light_on;
    } macc_view_t;

    function automatic logic [7:0] seg_digit(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7c;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h67;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // tens digit of a value below 64
    function automatic logic [3:0] digit_tens(input logic [5:0] v);
        logic [3:0] t;
        priority if (v >= 6'd60) t = 4'd6;
        else if (v >= 6'd50)     t = 4'd5;
        else if (v >= 6'd40)     t = 4'd4;
        else if (v >= 6'd30)     t = 4'd3;
        else if (v >= 6'd20)     t = 4'd2;
        else if (v >= 6'd10)     t = 4'd1;
        else                     t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] digit_ones(input logic [5:0] v);
        logic [5:0] r;
        r = v - 6'(digit_tens(v)) * 6'd10;
        return r[3:0];
    endfunction

    // two numbers as XX.YY
    function automatic seg_quad_t show_pair(input logic [5:0] l, input logic [5:0] r);
        seg_quad_t q;
        q[0] = seg_digit(digit_tens(l));
        q[1] = seg_digit(digit_ones(l)) | SEG_DP;
        q[2] = seg_digit(digit_tens(r));
        q[3] = seg_digit(digit_ones(r));
        return q;
    endfunction

endpackage
`default_nettype wire

@@ src/macc_cmd_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// macc_cmd_if
// Event channel: valid/ready handshake with command and light sample.
// ---------------------------------------------------------------------------
interface macc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [9:0] adc_sample;

    modport source (output valid, output command, output adc_sample, input ready);
    modport sink   (input valid, input command, input adc_sample, output ready);
endinterface
`default_nettype wire

@@ src/macc_res_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// macc_res_if
// Result channel: valid/ready handshake with mode, menu, display and flags.
// ---------------------------------------------------------------------------
interface macc_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] mode_now;
    logic [2:0] menu_index;
    logic [7:0] seg_left;
    logic [7:0] seg_mid_left;
    logic [7:0] seg_mid_right;
    logic [7:0] seg_right;
    logic [6:0] led_pattern;
    logic       timer_armed;
    logic       light_armed;

    modport source (
        output valid, output mode_now, output menu_index,
        output seg_left, output seg_mid_left, output seg_mid_right, output seg_right,
        output led_pattern, output timer_armed, output light_armed,
        input ready
    );
    modport sink (
        input valid, input mode_now, input menu_index,
        input seg_left, input seg_mid_left, input seg_mid_right, input seg_right,
        input led_pattern, input timer_armed, input light_armed,
        output ready
    );
endinterface
`default_nettype wire

@@ src/macc_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// macc_ctrl
// Clock, alarm and menu state; applies one event per fire in a single pass.
// ---------------------------------------------------------------------------
module macc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire logic [1:0]          command,
    input  wire logic [9:0]          adc_sample,
    output macc_pkg::macc_view_t     view
);
    import macc_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [2:0]  menu_pos_reg, menu_pos_next;
    logic [1:0]  menu_group_reg, menu_group_next;
    logic [5:0]  clk_second_reg, clk_second_next;
    logic [5:0]  clk_minute_reg, clk_minute_next;
    logic [4:0]  clk_hour_reg, clk_hour_next;
    logic [15:0] clk_day_reg, clk_day_next;
    logic [4:0]  alm_day_reg, alm_day_next;
    logic [4:0]  alm_hour_reg, alm_hour_next;
    logic [5:0]  alm_minute_reg, alm_minute_next;
    logic [3:0]  light_low_reg, light_low_next;
    logic [3:0]  light_high_reg, light_high_next;
    logic        edit_high_reg, edit_high_next;
    logic        clock_field_reg, clock_field_next;
    logic [1:0]  timer_field_reg, timer_field_next;
    logic        timer_on_reg, timer_on_next;
    logic        light_on_reg, light_on_next;
    logic [3:0]  light_level_reg, light_level_next;

    logic [15:0] sample_prod;
    logic [3:0]  sample_quot;
    logic [3:0]  sample_level;

    // sample/100 as (sample*41)>>12, exact for 10-bit samples; level 10 wraps to 0
    assign sample_prod  = {6'd0, adc_sample} * 16'd41;
    assign sample_quot  = sample_prod[15:12];
    assign sample_level = (sample_quot == 4'd10) ? 4'd0 : sample_quot;

    always_comb
    begin
        mode_next        = mode_reg;
        menu_pos_next    = menu_pos_reg;
        menu_group_next  = menu_group_reg;
        clk_second_next  = clk_second_reg;
        clk_minute_next  = clk_minute_reg;
        clk_hour_next    = clk_hour_reg;
        clk_day_next     = clk_day_reg;
        alm_day_next     = alm_day_reg;
        alm_hour_next    = alm_hour_reg;
        alm_minute_next  = alm_minute_reg;
        light_low_next   = light_low_reg;
        light_high_next  = light_high_reg;
        edit_high_next   = edit_high_reg;
        clock_field_next = clock_field_reg;
        timer_field_next = timer_field_reg;
        timer_on_next    = timer_on_reg;
        light_on_next    = light_on_reg;
        light_level_next = light_level_reg;

        if (fire)
        begin
            unique case (cmd_t'(command))
                CMD_TICK:
                begin
                    if (mode_reg != MODE_SET_CLOCK)
                    begin
                        if (clk_second_reg >= 6'd59)
                        begin
                            clk_second_next = 6'd0;
                            if (clk_minute_reg >= 6'd59)
                            begin
                                clk_minute_next = 6'd0;
                                if (clk_hour_reg >= 5'd23)
                                begin
                                    clk_hour_next = 5'd0;
                                    clk_day_next  = clk_day_reg + 16'd1;
                                end
                                else
                                begin
                                    clk_hour_next = clk_hour_reg + 5'd1;
                                end
                            end
                            else
                            begin
                                clk_minute_next = clk_minute_reg + 6'd1;
                            end
                        end
                        else
                        begin
                            clk_second_next = clk_second_reg + 6'd1;
                        end
                    end
                    // alarm check sees the advanced clock
                    if (timer_on_reg)
                    begin
                        if ({11'd0, alm_day_reg} == clk_day_next &&
                            alm_hour_reg == clk_hour_next &&
                            alm_minute_reg == clk_minute_next &&
                            clk_second_next == 6'd0)
                        begin
                            mode_next    = MODE_ALARM;
                            clk_day_next = 16'd0;
                        end
                    end
                    else if (light_on_reg)
                    begin
                        if (light_low_reg > light_level_reg ||
                            light_high_reg < light_level_reg)
                        begin
                            mode_next = MODE_ALARM;
                        end
                    end
                end
                CMD_NEXT:
                begin
                    unique case (mode_reg)
                        MODE_SET_CLOCK:
                        begin
                            if (!clock_field_reg)
                                clk_hour_next = (clk_hour_reg >= 5'd23) ? 5'd0
                                                                         : clk_hour_reg + 5'd1;
                            else
                                clk_minute_next = (clk_minute_reg >= 6'd59) ? 6'd0
                                                                             : clk_minute_reg + 6'd1;
                        end
                        MODE_SET_TIMER:
                        begin
                            priority case (timer_field_reg)
                                TFIELD_DAY:
                                    alm_day_next = (alm_day_reg >= TIMER_DAY_SPAN - 5'd1) ? 5'd0
                                                                                   : alm_day_reg + 5'd1;
                                TFIELD_HOUR:
                                    alm_hour_next = (alm_hour_reg >= 5'd23) ? 5'd0
                                                                             : alm_hour_reg + 5'd1;
                                default:
                                    alm_minute_next = (alm_minute_reg >= 6'd59) ? 6'd0
                                                                                 : alm_minute_reg + 6'd1;
                            endcase
                        end
                        MODE_SHOW_LIGHT:
                            mode_next = MODE_MENU;
                        MODE_SET_LIGHT:
                        begin
                            if (edit_high_reg)
                                light_high_next = (light_high_reg >= 4'd10) ? 4'd0
                                                                             : light_high_reg + 4'd1;
                            else
                                light_low_next = (light_low_reg >= 4'd10) ? 4'd0
                                                                           : light_low_reg + 4'd1;
                        end
                        MODE_MENU:
                        begin
                            menu_pos_next = (menu_pos_reg >= 3'd6) ? 3'd0 : menu_pos_reg + 3'd1;
                            priority if (menu_pos_next <= 3'd1) menu_group_next = GRP_GET;
                            else if (menu_pos_next <= 3'd4)     menu_group_next = GRP_SET;
                            else                                menu_group_next = GRP_CLEAR;
                        end
                        MODE_ALARM:
                        begin
                            mode_next     = MODE_MENU;
                            timer_on_next = 1'b0;
                            light_on_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_CONFIRM:
                begin
                    unique case (mode_reg)
                        MODE_SET_CLOCK:
                        begin
                            clock_field_next = ~clock_field_reg;
                            if (clock_field_reg)
                                mode_next = MODE_MENU;
                        end
                        MODE_SET_TIMER:
                        begin
                            priority case (timer_field_reg)
                                TFIELD_DAY:  timer_field_next = TFIELD_HOUR;
                                TFIELD_HOUR: timer_field_next = TFIELD_MINUTE;
                                default:
                                begin
                                    timer_field_next = TFIELD_DAY;
                                    mode_next        = MODE_MENU;
                                    timer_on_next    = 1'b1;
                                end
                            endcase
                        end
                        MODE_SHOW_LIGHT, MODE_SHOW_CLOCK, MODE_ALARM:
                            mode_next = MODE_MENU;
                        MODE_SET_LIGHT:
                        begin
                            edit_high_next = ~edit_high_reg;
                            if (edit_high_reg)
                            begin
                                mode_next     = MODE_MENU;
                                light_on_next = 1'b1;
                            end
                        end
                        MODE_CLR_LIGHT:
                        begin
                            light_on_next = 1'b0;
                            mode_next     = MODE_MENU;
                        end
                        MODE_CLR_TIMER:
                        begin
                            timer_on_next = 1'b0;
                            mode_next     = MODE_MENU;
                        end
                        MODE_MENU:
                            mode_next = mode_t'({1'b0, menu_pos_reg});
                        default:
                        begin
                        end
                    endcase
                end
                CMD_SAMPLE:
                    light_level_next = sample_level;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_SET_CLOCK;
            menu_pos_reg    <= 3'd0;
            menu_group_reg  <= GRP_GET;
            clk_second_reg  <= 6'd0;
            clk_minute_reg  <= 6'd0;
            clk_hour_reg    <= 5'd0;
            clk_day_reg     <= 16'd0;
            alm_day_reg     <= 5'd0;
            alm_hour_reg    <= 5'd0;
            alm_minute_reg  <= 6'd0;
            light_low_reg   <= 4'd0;
            light_high_reg  <= 4'd0;
            edit_high_reg   <= 1'b0;
            clock_field_reg <= 1'b0;
            timer_field_reg <= TFIELD_DAY;
            timer_on_reg    <= 1'b0;
            light_on_reg    <= 1'b0;
            light_level_reg <= 4'd0;
        end
        else
        begin
            mode_reg        <= mode_next;
            menu_pos_reg    <= menu_pos_next;
            menu_group_reg  <= menu_group_next;
            clk_second_reg  <= clk_second_next;
            clk_minute_reg  <= clk_minute_next;
            clk_hour_reg    <= clk_hour_next;
            clk_day_reg     <= clk_day_next;
            alm_day_reg     <= alm_day_next;
            alm_hour_reg    <= alm_hour_next;
            alm_minute_reg  <= alm_minute_next;
            light_low_reg   <= light_low_next;
            light_high_reg  <= light_high_next;
            edit_high_reg   <= edit_high_next;
            clock_field_reg <= clock_field_next;
            timer_field_reg <= timer_field_next;
            timer_on_reg    <= timer_on_next;
            light_on_reg    <= light_on_next;
            light_level_reg <= light_level_next;
        end
    end

    always_comb
    begin
        view.mode            = mode_next;
        view.menu_pos        = menu_pos_next;
        view.menu_group      = menu_group_next;
        view.clk_hour        = clk_hour_next;
        view.clk_minute      = clk_minute_next;
        view.alm_day         = alm_day_next;
        view.alm_hour        = alm_hour_next;
        view.alm_minute      = alm_minute_next;
        view.light_low       = light_low_next;
        view.light_high      = light_high_next;
        view.light_level     = light_level_next;
        view.timer_field_sel = timer_field_next;
        view.timer_on        = timer_on_next;
        view.light_on        = light_on_next;
    end

endmodule
`default_nettype wire

@@ src/macc_disp.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// macc_disp
// Seven-segment decode per mode; clear modes keep the last shown patterns.
// ---------------------------------------------------------------------------
module macc_disp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire macc_pkg::macc_view_t view,
    output macc_pkg::seg_quad_t      segs
);
    import macc_pkg::*;

    seg_quad_t held_reg;
    seg_quad_t shown;
    logic      hold;

    always_comb
    begin
        shown = held_reg;
        hold  = 1'b0;
        unique case (view.mode)
            MODE_MENU:
            begin
                priority case (view.menu_group)
                    GRP_GET: shown = {seg_digit({1'b0, view.menu_pos}), SEG_T, SEG_E, SEG_G};
                    GRP_SET: shown = {seg_digit({1'b0, view.menu_pos}), SEG_T, SEG_E, SEG_S};
                    default: shown = {seg_digit({1'b0, view.menu_pos}), SEG_S, SEG_L, SEG_C};
                endcase
            end
            MODE_SHOW_CLOCK, MODE_SET_CLOCK:
                shown = show_pair({1'b0, view.clk_hour}, view.clk_minute);
            MODE_SET_TIMER:
            begin
                if (view.timer_field_sel == TFIELD_DAY)
                begin
                    shown[0] = SEG_D;
                    shown[1] = SEG_Y;
                    shown[2] = seg_digit(digit_tens({1'b0, view.alm_day}));
                    shown[3] = seg_digit(digit_ones({1'b0, view.alm_day}));
                end
                else
                begin
                    shown = show_pair({1'b0, view.alm_hour}, view.alm_minute);
                end
            end
            MODE_SET_LIGHT:
                shown = show_pair({2'b0, view.light_low}, {2'b0, view.light_high});
            MODE_ALARM:
                shown = {SEG_N, SEG_A, SEG_L, SEG_A};
            MODE_SHOW_LIGHT:
            begin
                shown[0] = SEG_L;
                shown[1] = SEG_T;
                shown[2] = seg_digit(digit_tens({2'b0, view.light_level}));
                shown[3] = seg_digit(digit_ones({2'b0, view.light_level}));
            end
            default:
                hold = 1'b1;
        endcase
    end

    assign segs = hold ? held_reg : shown;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (fire)
            held_reg <= segs;
    end

endmodule
`default_nettype wire

@@ src/menu_alarm_clock_controller.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// menu_alarm_clock_controller
// Two-button menu alarm clock: events in, mode/display/LED results out.
// ---------------------------------------------------------------------------
// Takes one event (second tick, next, confirm, light sample) per cycle and
// returns one result per event, in order. An accepted event sits in an input
// register until it fires, the state update and display decode run in a single
// pass, and the result lands in an output register as the event fires; one
// event per cycle sustained while the result side keeps up. A stalled result
// holds the pipeline; the input register still refills when it is empty. No
// startup sweep: the block is ready right after reset, which leaves it in
// set-clock mode at 00.00.
module menu_alarm_clock_controller (
    input  wire logic clk,
    input  wire logic rst_n,
    macc_cmd_if.sink  cmd,
    macc_res_if.source res
);
    import macc_pkg::*;

    logic       cmd_valid_reg;
    logic [1:0] command_reg;
    logic [9:0] sample_reg;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       advance;
    logic       fire;

    macc_view_t view;
    seg_quad_t  segs;

    logic [3:0] mode_now_reg;
    logic [2:0] menu_index_reg;
    seg_quad_t  segs_reg;
    logic [6:0] led_reg;
    logic       timer_armed_reg;
    logic       light_armed_reg;

    assign advance   = !res_valid_reg || res.ready;
    assign fire      = cmd_valid_reg && advance;
    assign cmd.ready = !cmd_valid_reg || advance;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
                cmd_valid_reg <= cmd.valid;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            command_reg <= cmd.command;
            sample_reg  <= cmd.adc_sample;
        end
    end

    macc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .command    (command_reg),
        .adc_sample (sample_reg),
        .view       (view)
    );

    macc_disp u_disp (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .view  (view),
        .segs  (segs)
    );

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mode_now_reg    <= view.mode;
            menu_index_reg  <= view.menu_pos;
            segs_reg        <= segs;
            led_reg         <= 7'(8'd1 << view.menu_pos);
            timer_armed_reg <= view.timer_on;
            light_armed_reg <= view.light_on;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.mode_now      = mode_now_reg;
    assign res.menu_index    = menu_index_reg;
    assign res.seg_left      = segs_reg[0];
    assign res.seg_mid_left  = segs_reg[1];
    assign res.seg_mid_right = segs_reg[2];
    assign res.seg_right     = segs_reg[3];
    assign res.led_pattern   = led_reg;
    assign res.timer_armed   = timer_armed_reg;
    assign res.light_armed   = light_armed_reg;

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the menu alarm clock controller. Events go in over
// the command channel and a behavioral copy of the controller, kept inside the
// bench, works out the mode, menu, display and flags for each transfer. The
// checker compares every result with the oldest pending prediction. Directed
// tests walk the menu, both alarms and the clear modes; random menu sessions,
// tick bursts and samples follow under several idle and stall mixes.
// ---------------------------------------------------------------------------
module tb_top;
    import macc_pkg::*;

    localparam int         CLK_HALF     = 6;
    localparam int         RESET_CYCLES = 11;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 10;
    localparam logic [2:0] MENU_LAST    = 3'd6;
    localparam logic [3:0] BOUND_MAX    = 4'd10;

    typedef struct packed {
        logic [3:0] mode;
        logic [2:0] menu;
        logic [7:0] seg0;
        logic [7:0] seg1;
        logic [7:0] seg2;
        logic [7:0] seg3;
        logic [6:0] led;
        logic       timer_armed;
        logic       light_armed;
    } panel_t;

    logic clk;
    logic rst_n;

    macc_cmd_if cmd_ch ();
    macc_res_if res_ch ();

    menu_alarm_clock_controller uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // controller state as the bench tracks it
    mode_t       m_mode;
    logic [2:0]  m_pos;
    logic [1:0]  m_group;
    logic [5:0]  clk_sec;
    logic [5:0]  clk_min;
    logic [4:0]  clk_hr;
    logic [15:0] clk_day;
    logic [4:0]  alm_d;
    logic [4:0]  alm_h;
    logic [5:0]  alm_m;
    logic [3:0]  lo_bound;
    logic [3:0]  hi_bound;
    logic [3:0]  light_lvl;
    logic        edit_hi;
    logic        clk_field;
    logic [1:0]  tmr_field;
    logic        tmr_on;
    logic        lgt_on;
    logic [7:0]  disp [0:3];

    panel_t awaited_panels [$];

    int mismatches     = 0;
    int events_sent    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    function automatic logic [7:0] digit_seg(input int d);
        logic [7:0] s;
        case (d)
            0:       s = 8'h3f;
            1:       s = 8'h06;
            2:       s = 8'h5b;
            3:       s = 8'h4f;
            4:       s = 8'h66;
            5:       s = 8'h6d;
            6:       s = 8'h7c;
            7:       s = 8'h07;
            8:       s = 8'h7f;
            default: s = 8'h67;
        endcase
        return s;
    endfunction

    task automatic show4(input logic [7:0] a, input logic [7:0] b,
                         input logic [7:0] c, input logic [7:0] d);
        disp[0] = a;
        disp[1] = b;
        disp[2] = c;
        disp[3] = d;
    endtask

    task automatic show_numbers(input int l, input int r);
        show4(digit_seg((l / 10) % 10), digit_seg(l % 10) | SEG_DP,
              digit_seg((r / 10) % 10), digit_seg(r % 10));
    endtask

    task automatic clear_model();
        m_mode    = MODE_SET_CLOCK;
        m_pos     = '0;
        m_group   = GRP_GET;
        clk_sec   = '0;
        clk_min   = '0;
        clk_hr    = '0;
        clk_day   = '0;
        alm_d     = '0;
        alm_h     = '0;
        alm_m     = '0;
        lo_bound  = '0;
        hi_bound  = '0;
        light_lvl = '0;
        edit_hi   = 1'b0;
        clk_field = 1'b0;
        tmr_field = TFIELD_DAY;
        tmr_on    = 1'b0;
        lgt_on    = 1'b0;
        show4(8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // one event applied to the tracked state, giving the panel it should show
    task automatic advance_controller(input cmd_t c, input logic [9:0] s, output panel_t p);
        case (c)
            CMD_TICK:
            begin
                if (m_mode != MODE_SET_CLOCK)
                begin
                    if (clk_sec >= 6'd59)
                    begin
                        clk_sec = '0;
                        if (clk_min >= 6'd59)
                        begin
                            clk_min = '0;
                            if (clk_hr >= 5'd23)
                            begin
                                clk_hr  = '0;
                                clk_day = clk_day + 16'd1;
                            end
                            else
                                clk_hr = clk_hr + 5'd1;
                        end
                        else
                            clk_min = clk_min + 6'd1;
                    end
                    else
                        clk_sec = clk_sec + 6'd1;
                end
                // alarm check runs on every tick, set-clock mode included
                if (tmr_on)
                begin
                    if ({11'd0, alm_d} == clk_day && alm_h == clk_hr && alm_m == clk_min
                        && clk_sec == 6'd0)
                    begin
                        m_mode  = MODE_ALARM;
                        clk_day = '0;
                    end
                end
                else if (lgt_on && (lo_bound > light_lvl || hi_bound < light_lvl))
                    m_mode = MODE_ALARM;
            end
            CMD_NEXT:
            begin
                case (m_mode)
                    MODE_SET_CLOCK:
                        if (!clk_field)
                            clk_hr = (clk_hr == 5'd23) ? 5'd0 : clk_hr + 5'd1;
                        else
                            clk_min = (clk_min == 6'd59) ? 6'd0 : clk_min + 6'd1;
                    MODE_SET_TIMER:
                        if (tmr_field == TFIELD_DAY)
                            alm_d = (alm_d == TIMER_DAY_SPAN - 5'd1) ? 5'd0 : alm_d + 5'd1;
                        else if (tmr_field == TFIELD_HOUR)
                            alm_h = (alm_h == 5'd23) ? 5'd0 : alm_h + 5'd1;
                        else
                            alm_m = (alm_m == 6'd59) ? 6'd0 : alm_m + 6'd1;
                    MODE_SHOW_LIGHT:
                        m_mode = MODE_MENU;
                    MODE_SET_LIGHT:
                        if (edit_hi)
                            hi_bound = (hi_bound == BOUND_MAX) ? 4'd0 : hi_bound + 4'd1;
                        else
                            lo_bound = (lo_bound == BOUND_MAX) ? 4'd0 : lo_bound + 4'd1;
                    MODE_MENU:
                    begin
                        m_pos = (m_pos >= MENU_LAST) ? 3'd0 : m_pos + 3'd1;
                        if (m_pos <= 3'd1)
                            m_group = GRP_GET;
                        else if (m_pos <= 3'd4)
                            m_group = GRP_SET;
                        else
                            m_group = GRP_CLEAR;
                    end
                    MODE_ALARM:
                    begin
                        m_mode = MODE_MENU;
                        tmr_on = 1'b0;
                        lgt_on = 1'b0;
                    end
                    default:
                        ;
                endcase
            end
            CMD_CONFIRM:
            begin
                case (m_mode)
                    MODE_SET_CLOCK:
                        if (!clk_field)
                            clk_field = 1'b1;
                        else
                        begin
                            clk_field = 1'b0;
                            m_mode    = MODE_MENU;
                        end
                    MODE_SET_TIMER:
                        if (tmr_field == TFIELD_DAY)
                            tmr_field = TFIELD_HOUR;
                        else if (tmr_field == TFIELD_HOUR)
                            tmr_field = TFIELD_MINUTE;
                        else
                        begin
                            tmr_field = TFIELD_DAY;
                            m_mode    = MODE_MENU;
                            tmr_on    = 1'b1;
                        end
                    MODE_SHOW_LIGHT, MODE_SHOW_CLOCK, MODE_ALARM:
                        m_mode = MODE_MENU;
                    MODE_SET_LIGHT:
                        if (!edit_hi)
                            edit_hi = 1'b1;
                        else
                        begin
                            edit_hi = 1'b0;
                            m_mode  = MODE_MENU;
                            lgt_on  = 1'b1;
                        end
                    MODE_CLR_LIGHT:
                    begin
                        lgt_on = 1'b0;
                        m_mode = MODE_MENU;
                    end
                    MODE_CLR_TIMER:
                    begin
                        tmr_on = 1'b0;
                        m_mode = MODE_MENU;
                    end
                    MODE_MENU:
                        m_mode = mode_t'({1'b0, m_pos});
                    default:
                        ;
                endcase
            end
            default:
                light_lvl = 4'((int'(s) / 100) % 10);
        endcase

        case (m_mode)
            MODE_MENU:
                if (m_group == GRP_GET)
                    show4(SEG_G, SEG_E, SEG_T, digit_seg(int'(m_pos)));
                else if (m_group == GRP_SET)
                    show4(SEG_S, SEG_E, SEG_T, digit_seg(int'(m_pos)));
                else
                    show4(SEG_C, SEG_L, SEG_S, digit_seg(int'(m_pos)));
            MODE_SHOW_CLOCK, MODE_SET_CLOCK:
                show_numbers(int'(clk_hr), int'(clk_min));
            MODE_SET_TIMER:
                if (tmr_field == TFIELD_DAY)
                    show4(SEG_D, SEG_Y, digit_seg((int'(alm_d) / 10) % 10),
                          digit_seg(int'(alm_d) % 10));
                else
                    show_numbers(int'(alm_h), int'(alm_m));
            MODE_SET_LIGHT:
                show_numbers(int'(lo_bound), int'(hi_bound));
            MODE_ALARM:
                show4(SEG_A, SEG_L, SEG_A, SEG_N);
            MODE_SHOW_LIGHT:
                show4(SEG_L, SEG_T, digit_seg((int'(light_lvl) / 10) % 10),
                      digit_seg(int'(light_lvl) % 10));
            default:
                ;   // clear modes keep what was last shown
        endcase

        p.mode        = m_mode;
        p.menu        = m_pos;
        p.seg0        = disp[0];
        p.seg1        = disp[1];
        p.seg2        = disp[2];
        p.seg3        = disp[3];
        p.led         = 7'(1 << m_pos);
        p.timer_armed = tmr_on;
        p.light_armed = lgt_on;
    endtask

    task automatic send_event(input cmd_t c, input logic [9:0] s);
        panel_t p;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= c;
        cmd_ch.adc_sample <= s;
        do
        begin
            @(posedge clk);
        end
        while (cmd_ch.ready !== 1'b1);
        advance_controller(c, s, p);
        awaited_panels.push_back(p);
        events_sent++;
    endtask

    task automatic press(input cmd_t c);
        send_event(c, 10'($urandom_range(0, 1023)));
    endtask

    task automatic goto_menu();
        // confirm walks every mode back to the menu within three presses
        while (m_mode != MODE_MENU)
            press(CMD_CONFIRM);
    endtask

    task automatic select_entry(input mode_t target);
        goto_menu();
        while (m_pos != 3'(target))
            press(CMD_NEXT);
        press(CMD_CONFIRM);
    endtask

    // set the timer to the next whole minute, then tick until it goes off
    task automatic arm_timer_soon();
        logic [4:0] h;
        logic [5:0] m;
        int         guard;
        h = clk_hr;
        m = (clk_min == 6'd59) ? 6'd0 : clk_min + 6'd1;
        if (clk_min == 6'd59)
            h = (clk_hr == 5'd23) ? 5'd0 : clk_hr + 5'd1;
        select_entry(MODE_SET_TIMER);
        while (m_mode == MODE_SET_TIMER)
        begin
            if (tmr_field == TFIELD_DAY)
                while (alm_d != clk_day[4:0])
                    press(CMD_NEXT);
            else if (tmr_field == TFIELD_HOUR)
                while (alm_h != h)
                    press(CMD_NEXT);
            else
                while (alm_m != m)
                    press(CMD_NEXT);
            press(CMD_CONFIRM);
        end
        guard = 0;
        while (m_mode != MODE_ALARM && guard < 62)
        begin
            press(CMD_TICK);
            guard++;
        end
    endtask

    task automatic menu_session();
        int steps;
        int pick;
        select_entry(mode_t'(4'($urandom_range(0, 6))));
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(20, 65)) press(CMD_NEXT);   // long runs reach the wraps
        steps = $urandom_range(0, 9);
        repeat (steps)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                press(CMD_NEXT);
            else if (pick < 70)
                press(CMD_CONFIRM);
            else if (pick < 85)
                press(CMD_TICK);
            else
                press(CMD_SAMPLE);
        end
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        int pick;
        int n;
        stop_at = events_sent + count;
        while (events_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_event(cmd_t'(2'($urandom_range(0, 3))), 10'($urandom_range(0, 1023)));
            else if (pick < 24)
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
                repeat (n) press(CMD_TICK);
            end
            else if (pick < 36)
                press(CMD_SAMPLE);
            else if (pick < 80)
                menu_session();
            else if (pick < 84 && clk_day < TIMER_DAY_SPAN)
                arm_timer_soon();
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    if ($urandom_range(0, 1) != 0)
                        press(CMD_NEXT);
                    else
                        press(CMD_CONFIRM);
                end
            end
        end
    endtask

    task automatic test_set_clock();
        press(CMD_TICK);      // frozen in set-clock mode
        press(CMD_NEXT);
        press(CMD_CONFIRM);
        press(CMD_NEXT);
        press(CMD_CONFIRM);
    endtask

    task automatic test_light_samples();
        send_event(CMD_SAMPLE, 10'd0);
        send_event(CMD_SAMPLE, 10'h3ff);   // 1023 folds back to level 0
        send_event(CMD_SAMPLE, 10'd999);
        send_event(CMD_SAMPLE, 10'd100);
    endtask

    task automatic test_timer_alarm();
        arm_timer_soon();
        press(CMD_NEXT);      // next out of alarm drops both flags
    endtask

    task automatic test_light_alarm();
        send_event(CMD_SAMPLE, 10'd950);
        select_entry(MODE_SET_LIGHT);
        while (m_mode == MODE_SET_LIGHT)
        begin
            if (!edit_hi)
                while (lo_bound != BOUND_MAX)
                    press(CMD_NEXT);
            else
                while (hi_bound != BOUND_MAX)
                    press(CMD_NEXT);
            press(CMD_CONFIRM);
        end
        press(CMD_TICK);
        press(CMD_CONFIRM);   // confirm out of alarm keeps the flags
        select_entry(MODE_CLR_LIGHT);
        press(CMD_NEXT);      // ignored, display held
        press(CMD_TICK);      // still armed, fires from the clear mode
        select_entry(MODE_CLR_LIGHT);
        press(CMD_CONFIRM);
    endtask

    task automatic test_clear_timer();
        select_entry(MODE_CLR_TIMER);
        press(CMD_NEXT);
        press(CMD_TICK);
        press(CMD_CONFIRM);
    endtask

    task automatic test_show_modes();
        select_entry(MODE_SHOW_CLOCK);
        press(CMD_NEXT);      // ignored in show clock
        press(CMD_TICK);
        press(CMD_CONFIRM);
        select_entry(MODE_SHOW_LIGHT);
        send_event(CMD_SAMPLE, 10'd512);
        press(CMD_NEXT);
    endtask

    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 80;
        repeat (16) send_event(cmd_t'(2'($urandom_range(0, 3))), 10'($urandom_range(0, 1023)));
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(60);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct  = 58;
        recv_stall_pct = 0;
        random_traffic(60);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        random_traffic(60);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        random_traffic(60);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ERROR %s: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result side: random stall, or a long hold-off when one is requested
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        panel_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (awaited_panels.size() == 0)
            begin
                $display("%0t ERROR unexpected transfer: expected none, got mode %0h",
                         $time, res_ch.mode_now);
                mismatches++;
            end
            else
            begin
                want = awaited_panels.pop_front();
                check_field("mode_now", want.mode, res_ch.mode_now);
                check_field("menu_index", want.menu, res_ch.menu_index);
                check_field("seg_left", want.seg0, res_ch.seg_left);
                check_field("seg_mid_left", want.seg1, res_ch.seg_mid_left);
                check_field("seg_mid_right", want.seg2, res_ch.seg_mid_right);
                check_field("seg_right", want.seg3, res_ch.seg_right);
                check_field("led_pattern", want.led, res_ch.led_pattern);
                check_field("timer_armed", want.timer_armed, res_ch.timer_armed);
                check_field("light_armed", want.light_armed, res_ch.light_armed);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ERROR timeout with %0d results pending", $time, awaited_panels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_TICK;
        cmd_ch.adc_sample <= '0;
        clear_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_set_clock();
        test_light_samples();
        test_timer_alarm();
        test_light_alarm();
        test_clear_timer();
        test_show_modes();
        test_result_backpressure();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        cmd_ch.valid <= 1'b0;
        while (awaited_panels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

@@ menu_alarm_clock_controller.f @@
src/macc_pkg.sv
src/macc_cmd_if.sv
src/macc_res_if.sv
src/macc_ctrl.sv
src/macc_disp.sv
src/menu_alarm_clock_controller.sv
test/tb_top.sv
